// ===== rtl/core/dsp_pkg.sv =====
// Shared constants for the shortest-path engine: field widths, distance
// codes, configuration register indexes and input function codes.
// No dependencies.
`timescale 1ns / 1ps

package dsp_pkg;

  // Fixed widths of the channel fields
  localparam int VERTEX_W    = 4;
  localparam int DIST_W      = 20;
  localparam int PATH_W      = 16;
  localparam int WEIGHT_IN_W = 16;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  // Results per run never exceed this many vertices
  localparam int RESULT_CAP = 16;

  // Distance table word holds distance and path row
  localparam int DWORD_W = DIST_W + PATH_W;

  // Unreachable marker and saturation ceiling
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_TOP = {{(DIST_W-1){1'b1}}, 1'b0};

  // Default parameter values
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT  = 1'b1;

  // Input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

endpackage

// ===== rtl/core/dsp_if.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on dsp_pkg for field widths.
`timescale 1ns / 1ps

interface dsp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [dsp_pkg::VERTEX_W-1:0]        from_vertex;
  logic [dsp_pkg::VERTEX_W-1:0]        to_vertex;
  logic [dsp_pkg::WEIGHT_IN_W-1:0]     arc_weight;
  logic                                arc_present;

  modport source (output valid, func, from_vertex, to_vertex, arc_weight, arc_present,
                  input ready);
  modport sink   (input valid, func, from_vertex, to_vertex, arc_weight, arc_present,
                  output ready);
endinterface

interface dsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [dsp_pkg::VERTEX_W-1:0]  vertex;
  logic [dsp_pkg::DIST_W-1:0]    distance;
  logic                          reachable;
  logic [dsp_pkg::PATH_W-1:0]    path_set;
  logic                          last;

  modport source (output valid, vertex, distance, reachable, path_set, last,
                  input ready);
  modport sink   (input valid, vertex, distance, reachable, path_set, last,
                  output ready);
endinterface

// ===== rtl/core/dsp_arc_store.sv =====
// Adjacency matrix memory: one word per arc holding {exists, weight}.
// Runs a clearing pass after reset. Depends on dsp_pkg.
`timescale 1ns / 1ps

module dsp_arc_store #(
  parameter int MAX_VERTICES = dsp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = dsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           wr_en,
  input  logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]   wr_addr,
  input  logic [WEIGHT_BITS:0]                           wr_data,
  input  logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]   rd_addr,
  output logic [WEIGHT_BITS:0]                           rd_data,
  output logic                                           busy
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  logic [WEIGHT_BITS:0] mem [DEPTH];
  logic                 clr_busy_r;
  logic [AW-1:0]        clr_addr_r;
  logic [WEIGHT_BITS:0] rd_data_r;

  // Sweep every entry to "no arc" after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Single write port, clear pass has priority
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// ===== rtl/core/dsp_dist_store.sv =====
// Distance table memory: one word per vertex holding {distance, path row}.
// One write and one registered read per cycle. Depends on dsp_pkg.
`timescale 1ns / 1ps

module dsp_dist_store (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [dsp_pkg::VERTEX_W-1:0]      wr_addr,
  input  logic [dsp_pkg::DWORD_W-1:0]       wr_data,
  input  logic [dsp_pkg::VERTEX_W-1:0]      rd_addr,
  output logic [dsp_pkg::DWORD_W-1:0]       rd_data
);

  logic [dsp_pkg::DWORD_W-1:0] mem [dsp_pkg::RESULT_CAP];
  logic [dsp_pkg::DWORD_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/dijkstra_shortest_paths.sv =====
// Single-source shortest-path engine over an adjacency matrix in memory.
// Input channel in_ch: a word with func = load writes one arc (weight and
// exists flag). A word with func = run searches from the
// configured source and returns one result word per vertex in use on out_ch,
// in vertex order, with last set on the final one.
// Configuration: cfg_we with cfg_index selects source vertex or vertex count;
// write only while idle.
// Run steps for n vertices in use: an init sweep of the distance table; if the
// source lies within them, search rounds, each a read scan of the distance table,
// then a scan of the picked vertex's matrix row through the one-port memories,
// at most n rounds, then one closing select scan that finds no vertex; then
// the result words, each read from the distance table and held until taken.
// One word is in flight at a time; in_ch.ready is low during a run.
// A stalled receiver holds the current result and the run waits.
// Reset: configuration returns to source 0, count 16, and the arc memory is
// swept to "no arc" over all MAX_VERTICES*MAX_VERTICES entries with in_ch.ready low.
// Depends on dsp_pkg, dsp_if, dsp_arc_store and dsp_dist_store.
`timescale 1ns / 1ps

module dijkstra_shortest_paths #(
  parameter int MAX_VERTICES = dsp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = dsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  dsp_in_if.sink                             in_ch,
  dsp_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [dsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int NV = (MAX_VERTICES < dsp_pkg::RESULT_CAP) ? MAX_VERTICES
                                                          : dsp_pkg::RESULT_CAP;
  localparam int SW = ((WEIGHT_BITS > dsp_pkg::DIST_W) ? WEIGHT_BITS
                                                       : dsp_pkg::DIST_W) + 1;
  localparam int VW = dsp_pkg::VERTEX_W;
  localparam int DW = dsp_pkg::DIST_W;
  localparam int PW = dsp_pkg::PATH_W;

  // Controller states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SEL  = 4'd2;
  localparam logic [3:0] S_SELD = 4'd3;
  localparam logic [3:0] S_REL  = 4'd4;
  localparam logic [3:0] S_RELD = 4'd5;
  localparam logic [3:0] S_ORD  = 4'd6;
  localparam logic [3:0] S_OLD  = 4'd7;
  localparam logic [3:0] S_OWT  = 4'd8;

  // Configuration registers
  logic [VW-1:0] cfg_src_r;
  logic [4:0]    cfg_cnt_r;

  // Controller registers
  logic [3:0]    state_r, state_nxt;
  logic [VW-1:0] cnt_r, cnt_nxt;
  logic [4:0]    n_r, n_nxt;
  logic [VW-1:0] src_r, src_nxt;
  logic          srcv_r, srcv_nxt;
  logic [PW-1:0] fin_r, fin_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic [PW-1:0] bpath_r, bpath_nxt;
  logic [VW-1:0] pick_r, pick_nxt;
  logic          found_r, found_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic          p_rel_r, p_rel_nxt;
  logic [VW-1:0] p_idx_r, p_idx_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_vertex_r;
  logic [DW-1:0] out_dist_r;
  logic          out_reach_r;
  logic [PW-1:0] out_path_r;
  logic          out_last_r;
  logic          out_load;

  // Memory ports
  logic                   arc_we;
  logic [AW-1:0]          arc_waddr;
  logic [WEIGHT_BITS:0]   arc_wdata;
  logic [AW-1:0]          arc_raddr;
  logic [WEIGHT_BITS:0]   arc_rdata;
  logic                   arc_busy;
  logic                   dist_we;
  logic [VW-1:0]          dist_waddr;
  logic [dsp_pkg::DWORD_W-1:0] dist_wdata;
  logic [dsp_pkg::DWORD_W-1:0] dist_rdata;

  // Datapath
  logic [DW-1:0]  rd_dist;
  logic [PW-1:0]  rd_path;
  logic           sel_take;
  logic [SW-1:0]  sum;
  logic [DW-1:0]  sum_sat;
  logic           rel_we;
  logic           load_ok;
  logic           accept;
  logic [VW-1:0]  last_idx;
  logic [4:0]     n_req;

  dsp_arc_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_arc (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (arc_we),
    .wr_addr (arc_waddr),
    .wr_data (arc_wdata),
    .rd_addr (arc_raddr),
    .rd_data (arc_rdata),
    .busy    (arc_busy)
  );

  dsp_dist_store u_dist (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_waddr),
    .wr_data (dist_wdata),
    .rd_addr (cnt_r),
    .rd_data (dist_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_src_r <= '0;
      cfg_cnt_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsp_pkg::CFG_SOURCE: cfg_src_r <= cfg_data[VW-1:0];
        dsp_pkg::CFG_COUNT:  cfg_cnt_r <= cfg_data;
        default:             cfg_cnt_r <= cfg_cnt_r;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && !arc_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the vertex count into 1..NV
  always_comb begin
    n_req = cfg_cnt_r;
    if (n_req == 5'd0) begin
      n_req = 5'd1;
    end
    if (int'(n_req) > NV) begin
      n_req = 5'(NV);
    end
  end

  assign last_idx = VW'(n_r - 5'd1);

  // Arc load path
  assign load_ok   = (int'(in_ch.from_vertex) < MAX_VERTICES) &&
                     (int'(in_ch.to_vertex) < MAX_VERTICES);
  assign arc_we    = accept && (in_ch.func == dsp_pkg::FUNC_LOAD) && load_ok;
  assign arc_waddr = AW'(int'(in_ch.from_vertex) * MAX_VERTICES + int'(in_ch.to_vertex));
  assign arc_wdata = {in_ch.arc_present, WEIGHT_BITS'(in_ch.arc_weight)};
  assign arc_raddr = AW'(int'(pick_r) * MAX_VERTICES + int'(cnt_r));

  assign rd_dist = dist_rdata[dsp_pkg::DWORD_W-1:PW];
  assign rd_path = dist_rdata[PW-1:0];

  // Select scan: keep the first strictly nearest unfinished vertex
  assign sel_take = p_vld_r && !p_rel_r && !fin_r[p_idx_r] && (rd_dist < best_r);

  // Relax: saturated sum against the stored distance
  assign sum     = SW'(best_r) + SW'(arc_rdata[WEIGHT_BITS-1:0]);
  assign sum_sat = (sum > SW'(dsp_pkg::DIST_TOP)) ? dsp_pkg::DIST_TOP : sum[DW-1:0];
  assign rel_we  = p_vld_r && p_rel_r && !fin_r[p_idx_r] && arc_rdata[WEIGHT_BITS] &&
                   (sum_sat < rd_dist);

  // Distance table write: init sweep or relax update
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = cnt_r;
    dist_wdata = {dsp_pkg::DIST_INF, {PW{1'b0}}};
    if (state_r == S_INIT) begin
      dist_we = 1'b1;
      if (srcv_r && (cnt_r == src_r)) begin
        dist_wdata = {{DW{1'b0}}, PW'(1) << src_r};
      end
    end else if (rel_we) begin
      dist_we    = 1'b1;
      dist_waddr = p_idx_r;
      dist_wdata = {sum_sat, bpath_r | (PW'(1) << p_idx_r)};
    end
  end

  // Controller
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    src_nxt   = src_r;
    srcv_nxt  = srcv_r;
    fin_nxt   = fin_r;
    best_nxt  = best_r;
    bpath_nxt = bpath_r;
    pick_nxt  = pick_r;
    found_nxt = found_r;
    p_vld_nxt = (state_r == S_SEL) || (state_r == S_REL);
    p_rel_nxt = (state_r == S_REL);
    p_idx_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    out_load  = 1'b0;

    if (sel_take) begin
      best_nxt  = rd_dist;
      bpath_nxt = rd_path;
      pick_nxt  = p_idx_r;
      found_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_ch.func == dsp_pkg::FUNC_RUN)) begin
          n_nxt     = n_req;
          src_nxt   = cfg_src_r;
          srcv_nxt  = (5'(cfg_src_r) < n_req);
          fin_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (cnt_r == last_idx) begin
          cnt_nxt   = '0;
          best_nxt  = dsp_pkg::DIST_INF;
          found_nxt = 1'b0;
          state_nxt = srcv_r ? S_SEL : S_ORD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SEL: begin
        if (cnt_r == last_idx) begin
          state_nxt = S_SELD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SELD: begin
        cnt_nxt = '0;
        if (found_nxt) begin
          fin_nxt   = fin_r | (PW'(1) << pick_nxt);
          state_nxt = S_REL;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_REL: begin
        if (cnt_r == last_idx) begin
          state_nxt = S_RELD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RELD: begin
        cnt_nxt   = '0;
        best_nxt  = dsp_pkg::DIST_INF;
        found_nxt = 1'b0;
        state_nxt = S_SEL;
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OWT;
      end
      S_OWT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (cnt_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      p_rel_r     <= 1'b0;
      found_r     <= 1'b0;
      fin_r       <= '0;
      cnt_r       <= '0;
      n_r         <= 5'd1;
      srcv_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= p_vld_nxt;
      p_rel_r     <= p_rel_nxt;
      found_r     <= found_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      srcv_r      <= srcv_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    best_r  <= best_nxt;
    bpath_r <= bpath_nxt;
    pick_r  <= pick_nxt;
    p_idx_r <= p_idx_nxt;
    if (out_load) begin
      out_vertex_r <= cnt_r;
      out_dist_r   <= rd_dist;
      out_reach_r  <= (rd_dist != dsp_pkg::DIST_INF);
      out_path_r   <= (rd_dist != dsp_pkg::DIST_INF) ? rd_path : '0;
      out_last_r   <= (cnt_r == last_idx);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.vertex    = out_vertex_r;
  assign out_ch.distance  = out_dist_r;
  assign out_ch.reachable = out_reach_r;
  assign out_ch.path_set  = out_path_r;
  assign out_ch.last      = out_last_r;

endmodule

// ===== rtl/core/dsp_checker.sv =====
// Port-level checks for the shortest-path engine, bound to the top level.
// Depends on dsp_pkg and dijkstra_shortest_paths.
`timescale 1ns / 1ps

module dsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [dsp_pkg::VERTEX_W-1:0]     out_vertex,
  input logic [dsp_pkg::DIST_W-1:0]       out_distance
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) && $stable(out_distance))
    else $error("stalled result word changed");

  // Drop input acceptance while a result is pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Clear pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("input ready during clearing pass");

  // Each result is fetched anew after being taken
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result valid in cycle after handoff");

endmodule

bind dijkstra_shortest_paths dsp_checker u_dsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_vertex   (out_ch.vertex),
  .out_distance (out_ch.distance)
);

// ===== tb/sv/dijkstra_shortest_paths_tb.sv =====
// Self-checking bench for the shortest-path engine: loads random graphs,
// runs searches under several source/count settings, checks every result word.
// Depends on dsp_pkg, dsp_if and the dijkstra_shortest_paths RTL.
`timescale 1ns / 1ps

module dijkstra_shortest_paths_tb;

  typedef struct packed {
    logic                            func;
    logic [dsp_pkg::VERTEX_W-1:0]    from_v;
    logic [dsp_pkg::VERTEX_W-1:0]    to_v;
    logic [dsp_pkg::WEIGHT_IN_W-1:0] weight;
    logic                            present;
  } arc_word_t;

  typedef struct packed {
    logic [dsp_pkg::VERTEX_W-1:0] vertex;
    logic [dsp_pkg::DIST_W-1:0]   distance;
    logic                         reachable;
    logic [dsp_pkg::PATH_W-1:0]   path_set;
    logic                         last;
  } path_word_t;

  localparam int LIMIT       = 2000000;
  localparam int HOLD_CYCLES = 600;
  localparam int CDW         = dsp_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [dsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dsp_in_if in_ch ();
  dsp_out_if out_ch ();

  dijkstra_shortest_paths dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow graph and configuration
  logic [15:0] wt_mem [256];
  logic        arc_mem [256];
  logic [3:0]  src_reg;
  logic [4:0]  cnt_reg;

  arc_word_t  pending_words[$];
  path_word_t expected_paths[$];
  int errors = 0;
  int cycles = 0;
  bit in_acc = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  // Compute the results of one run against the shadow graph
  task automatic predict_search();
    logic [19:0] dist_v [16];
    logic [15:0] path [16];
    logic [15:0] done;
    logic [20:0] sum;
    logic [19:0] best;
    int n, pick;
    bit found;
    path_word_t r;
    n = (cnt_reg == 5'd0) ? 1 : ((int'(cnt_reg) > 16) ? 16 : int'(cnt_reg));
    done = '0;
    for (int v = 0; v < 16; v++) begin
      dist_v[v] = dsp_pkg::DIST_INF;
      path[v] = '0;
    end
    if (int'(src_reg) < n) begin
      dist_v[src_reg] = '0;
      path[src_reg] = 16'(1) << src_reg;
      for (int rnd = 0; rnd < n; rnd++) begin
        best = dsp_pkg::DIST_INF;
        pick = 0;
        found = 1'b0;
        for (int w = 0; w < n; w++) begin
          if (!done[w] && dist_v[w] < best) begin
            best = dist_v[w];
            pick = w;
            found = 1'b1;
          end
        end
        if (!found) break;
        done[pick] = 1'b1;
        for (int w = 0; w < n; w++) begin
          if (!done[w] && arc_mem[pick*16+w]) begin
            sum = {1'b0, best} + 21'(wt_mem[pick*16+w]);
            if (sum > 21'(dsp_pkg::DIST_TOP)) sum = 21'(dsp_pkg::DIST_TOP);
            if (sum[19:0] < dist_v[w]) begin
              dist_v[w] = sum[19:0];
              path[w] = path[pick] | (16'(1) << w);
            end
          end
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      r.vertex = 4'(v);
      r.distance = dist_v[v];
      r.reachable = (dist_v[v] != dsp_pkg::DIST_INF);
      r.path_set = r.reachable ? path[v] : '0;
      r.last = (v + 1 == n);
      expected_paths.push_back(r);
    end
  endtask

  // Track accepted input words: update shadow graph, predict runs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      for (int i = 0; i < 256; i++) begin
        arc_mem[i] <= 1'b0;
        wt_mem[i] <= '0;
      end
    end else if (in_ch.valid && in_ch.ready) begin
      if (in_ch.func == dsp_pkg::FUNC_LOAD) begin
        wt_mem[{in_ch.from_vertex, in_ch.to_vertex}] <= in_ch.arc_weight;
        arc_mem[{in_ch.from_vertex, in_ch.to_vertex}] <= in_ch.arc_present;
      end else begin
        predict_search();
      end
    end
  end

  // Driver: offer queued words with random gaps
  int gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= dsp_pkg::FUNC_LOAD;
      in_ch.from_vertex <= '0;
      in_ch.to_vertex <= '0;
      in_ch.arc_weight <= '0;
      in_ch.arc_present <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // hold the word
    end else if (gap > 0) begin
      in_ch.valid <= 1'b0;
      gap <= gap - 1;
    end else if (pending_words.size() > 0) begin
      arc_word_t a;
      a = pending_words.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.func <= a.func;
      in_ch.from_vertex <= a.from_v;
      in_ch.to_vertex <= a.to_v;
      in_ch.arc_weight <= a.weight;
      in_ch.arc_present <= a.present;
      gap <= ($urandom_range(0, 9) < 6) ? 0 :
             (($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Count the long receiver hold-off once requested
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES)
      hold_cnt <= hold_cnt + 1;
  end

  // Receiver: random stalls, plus the long hold-off
  int stall = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
    end else if (stall > 0) begin
      out_ch.ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) < 3)
        stall <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      path_word_t got, exp_w;
      got = '{out_ch.vertex, out_ch.distance, out_ch.reachable, out_ch.path_set,
              out_ch.last};
      if (expected_paths.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, got);
        errors++;
      end else begin
        exp_w = expected_paths.pop_front();
        if (got !== exp_w) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp_w, got);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("[dijkstra_shortest_paths] ERROR");
      $finish;
    end
  end

  function automatic arc_word_t load_word(int f, int t, int w, bit p);
    arc_word_t a;
    a.func = dsp_pkg::FUNC_LOAD;
    a.from_v = 4'(f);
    a.to_v = 4'(t);
    a.weight = 16'(w);
    a.present = p;
    return a;
  endfunction

  function automatic arc_word_t run_word();
    arc_word_t a;
    a.func = dsp_pkg::FUNC_RUN;
    a.from_v = 4'($urandom);
    a.to_v = 4'($urandom);
    a.weight = 16'($urandom);
    a.present = 1'($urandom);
    return a;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_paths.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [dsp_pkg::CFG_INDEX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CDW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dsp_pkg::CFG_SOURCE) src_reg = 4'(val);
    else cnt_reg = 5'(val);
  endtask

  // Random phase: random arcs into the first n vertices, then a run
  task automatic random_graph(int n, int loads);
    int w;
    for (int k = 0; k < loads; k++) begin
      case ($urandom_range(0, 3))
        0: w = $urandom_range(0, 65535);
        1: w = 65535;
        default: w = $urandom_range(0, 20);
      endcase
      pending_words.push_back(load_word($urandom_range(0, n - 1 + (k % 7 == 0 ? 16 - n : 0)),
                                        $urandom_range(0, n - 1), w, $urandom_range(0, 3) != 0));
    end
    pending_words.push_back(run_word());
  endtask

  initial begin
    int settings[8][2] = '{'{0, 16}, '{15, 16}, '{3, 1}, '{0, 0}, '{5, 4},
                           '{2, 8}, '{9, 31}, '{7, 6}};
    src_reg = 0;
    cnt_reg = 16;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty graph run, chain with ties, long chain of maximum weights
    pending_words.push_back(run_word());
    pending_words.push_back(load_word(0, 1, 5, 1));
    pending_words.push_back(load_word(0, 2, 3, 1));
    pending_words.push_back(load_word(2, 1, 2, 1));
    pending_words.push_back(load_word(1, 3, 65535, 1));
    for (int k = 3; k < 15; k++)
      pending_words.push_back(load_word(k, k + 1, 65535, 1));
    pending_words.push_back(load_word(15, 0, 0, 1));
    pending_words.push_back(load_word(2, 3, 1, 0));
    pending_words.push_back(run_word());
    drain();

    // Long receiver hold while a run fills the block and loads back up
    hold_req = 1'b1;
    pending_words.push_back(run_word());
    for (int k = 0; k < 4; k++) pending_words.push_back(load_word(k, 15 - k, k, 1));
    wait (hold_cnt == HOLD_CYCLES);
    drain();

    // Random phases over a range of settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(dsp_pkg::CFG_SOURCE, settings[ph][0]);
      write_cfg(dsp_pkg::CFG_COUNT, settings[ph][1]);
      for (int g = 0; g < 2; g++)
        random_graph((settings[ph][1] == 0) ? 1 :
                     (settings[ph][1] > 16 ? 16 : settings[ph][1]), 12);
      drain();
    end

    if (errors == 0) begin
      $display("[dijkstra_shortest_paths] OK");
    end else begin
      $display("[dijkstra_shortest_paths] ERROR");
    end
    $finish;
  end
endmodule

// ===== dijkstra_shortest_paths.f =====
rtl/core/dsp_pkg.sv
rtl/core/dsp_if.sv
rtl/core/dsp_arc_store.sv
rtl/core/dsp_dist_store.sv
rtl/core/dijkstra_shortest_paths.sv
rtl/core/dsp_checker.sv
tb/sv/dijkstra_shortest_paths_tb.sv
